// ===== sv/sorted_key_value_table_assert.svh =====
// Assertion macros used by the checker file.
`ifndef SORTED_KEY_VALUE_TABLE_ASSERT_SVH
`define SORTED_KEY_VALUE_TABLE_ASSERT_SVH

// Consequent checked in the same cycle as the trigger.
`define SKVT_ASSERT_NOW(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error("sorted_key_value_table: same-cycle check failed");

// Consequent checked in the cycle after the trigger.
`define SKVT_ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("sorted_key_value_table: next-cycle check failed");

`endif

// ===== sv/skvt_pkg.sv =====
package skvt_pkg;

  localparam int CAPACITY   = 128;
  localparam int NAME_CHARS = 8;
  localparam int KEY_W      = 64;
  localparam int NUM_W      = 50;
  localparam int KEY_BYTES  = KEY_W / 8;

  // Match tree: first level ORs groups of cells, second level ORs groups.
  localparam int GROUP_SIZE = 16;
  localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  // Only the top NAME_CHARS bytes of a key take part.
  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} << ((KEY_BYTES - NAME_CHARS) * 8);

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    STATUS_UPDATED  = 3'd0,
    STATUS_INSERTED = 3'd1,
    STATUS_FULL     = 3'd2,
    STATUS_MISSING  = 3'd3,
    STATUS_FOUND    = 3'd4
  } status_t;

  typedef struct packed {
    op_t              opcode;
    logic [KEY_W-1:0] name_key;
    logic [NUM_W-1:0] phone_number;
  } cmd_word_t;

  typedef struct packed {
    status_t          status;
    logic [NUM_W-1:0] found_number;
  } rsp_word_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [NUM_W-1:0] number;
  } entry_t;

  // Broadcast controls to every cell of the chain.
  typedef struct packed {
    logic compare;
    logic insert;
    logic update;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GATHER,
    ST_RESOLVE,
    ST_COMMIT
  } fsm_state_t;

endpackage

// ===== sv/skvt_cell.sv =====
module skvt_cell import skvt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctl_t        ctl,
  input  logic [KEY_W-1:0] cmp_key,
  input  entry_t           new_entry,
  input  entry_t           left_entry,
  input  logic             left_above,
  output entry_t           entry,
  output logic             above,
  output logic             hit
);

  logic             valid;
  logic [KEY_W-1:0] key;
  logic [NUM_W-1:0] number;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.insert && above) begin
      valid <= left_above ? left_entry.valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.insert && above) begin
      // Shift right behind the insert point; the first cell above takes the new word.
      key    <= left_above ? left_entry.key : new_entry.key;
      number <= left_above ? left_entry.number : new_entry.number;
    end else if (ctl.update && hit) begin
      number <= new_entry.number;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.compare) begin
      hit   <= valid && (key == cmp_key);
      above <= !valid || (key > cmp_key);
    end
  end

  assign entry = '{valid: valid, key: key, number: number};

endmodule

// ===== sv/skvt_match_tree.sv =====
module skvt_match_tree import skvt_pkg::*; (
  input  logic                clk,
  input  logic [CAPACITY-1:0] hits,
  input  logic [NUM_W-1:0]    numbers [CAPACITY],
  output logic                any_hit,
  output logic [NUM_W-1:0]    hit_number
);

  logic [NUM_GROUPS-1:0] grp_hit;
  logic [NUM_W-1:0]      grp_number [NUM_GROUPS];
  logic [NUM_GROUPS-1:0] grp_hit_next;
  logic [NUM_W-1:0]      grp_number_next [NUM_GROUPS];
  logic                  any_hit_next;
  logic [NUM_W-1:0]      hit_number_next;

  // At most one cell matches, so an AND-OR select is enough.
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_hit_next[g]    = 1'b0;
      grp_number_next[g] = '0;
      for (int m = 0; m < GROUP_SIZE; m++) begin
        if (g * GROUP_SIZE + m < CAPACITY) begin
          grp_hit_next[g]    = grp_hit_next[g] | hits[g * GROUP_SIZE + m];
          grp_number_next[g] = grp_number_next[g]
                             | (numbers[g * GROUP_SIZE + m] & {NUM_W{hits[g * GROUP_SIZE + m]}});
        end
      end
    end
  end

  always_comb begin
    any_hit_next    = 1'b0;
    hit_number_next = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      any_hit_next    = any_hit_next | grp_hit[g];
      hit_number_next = hit_number_next | (grp_number[g] & {NUM_W{grp_hit[g]}});
    end
  end

  always_ff @(posedge clk) begin
    grp_hit    <= grp_hit_next;
    grp_number <= grp_number_next;
    any_hit    <= any_hit_next;
    hit_number <= hit_number_next;
  end

endmodule

// ===== sv/sorted_key_value_table.sv =====
// Channel  Direction  Handshake              Word
// cmd      in         cmd_valid / cmd_stall  opcode, name_key, phone_number
// rsp      out        rsp_valid / rsp_stall  status, found_number
//
// Every word passes these steps: the accept edge compares the key in all cells at
// once, the group and top registers of the OR tree gather the match, and the
// commit edge shifts or updates the cell chain and loads the result.
// A new word is taken only after the previous one commits, which waits for a free result
// register; a stalled result holds the commit and nothing else.
// Synchronous reset empties the table at once (per-cell occupied bits).
module sorted_key_value_table import skvt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cmd_word_t cmd,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_word_t rsp
);

  fsm_state_t       state;
  fsm_state_t       state_next;
  logic             cmd_accept;
  logic             commit_go;
  op_t              op;
  logic [KEY_W-1:0] key;
  logic [NUM_W-1:0] number;
  cell_ctl_t        ctl;
  entry_t           new_entry;
  logic [KEY_W-1:0] cmp_key;
  logic             table_full;
  logic             any_hit;
  logic [NUM_W-1:0] hit_number;
  rsp_word_t        rsp_next;

  entry_t              entries [CAPACITY];
  logic [CAPACITY-1:0] above_v;
  logic [CAPACITY-1:0] hit_v;
  logic [NUM_W-1:0]    numbers [CAPACITY];

  assign cmd_accept = cmd_valid && !cmd_stall;
  assign cmp_key    = cmd.name_key & KEY_MASK;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_stall  = 1'b1;
    commit_go  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd_stall = rst;
        if (cmd_valid) begin
          state_next = ST_GATHER;
        end
      end
      ST_GATHER:  state_next = ST_RESOLVE;
      ST_RESOLVE: state_next = ST_COMMIT;
      ST_COMMIT: begin
        // Hold until the result register is free.
        commit_go = !rsp_valid || !rsp_stall;
        if (commit_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      op     <= cmd.opcode;
      key    <= cmp_key;
      number <= cmd.phone_number;
    end
  end

  assign table_full  = entries[CAPACITY-1].valid;
  assign new_entry   = '{valid: 1'b1, key: key, number: number};
  assign ctl.compare = cmd_accept;
  assign ctl.update  = commit_go && (op == OP_ADD) && any_hit;
  assign ctl.insert  = commit_go && (op == OP_ADD) && !any_hit && !table_full;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      skvt_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .cmp_key    (cmp_key),
        .new_entry  (new_entry),
        .left_entry ('0),
        .left_above (1'b0),
        .entry      (entries[i]),
        .above      (above_v[i]),
        .hit        (hit_v[i])
      );
    end else begin : g_body
      skvt_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .cmp_key    (cmp_key),
        .new_entry  (new_entry),
        .left_entry (entries[i-1]),
        .left_above (above_v[i-1]),
        .entry      (entries[i]),
        .above      (above_v[i]),
        .hit        (hit_v[i])
      );
    end
    assign numbers[i] = entries[i].number;
  end

  skvt_match_tree u_tree (
    .clk        (clk),
    .hits       (hit_v),
    .numbers    (numbers),
    .any_hit    (any_hit),
    .hit_number (hit_number)
  );

  always_comb begin
    rsp_next.found_number = '0;
    if (op == OP_LOOKUP) begin
      if (any_hit) begin
        rsp_next.status       = STATUS_FOUND;
        rsp_next.found_number = hit_number;
      end else begin
        rsp_next.status = STATUS_MISSING;
      end
    end else if (any_hit) begin
      rsp_next.status = STATUS_UPDATED;
    end else if (table_full) begin
      rsp_next.status = STATUS_FULL;
    end else begin
      rsp_next.status = STATUS_INSERTED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit_go) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_go) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== sv/skvt_checker.sv =====
`include "sorted_key_value_table_assert.svh"

module skvt_checker import skvt_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      cmd_valid,
  input logic      cmd_stall,
  input cmd_word_t cmd,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input rsp_word_t rsp
);

  // A stalled result word holds.
  `SKVT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

  // The table works on one word at a time.
  `SKVT_ASSERT_NEXT(a_busy_after_accept, cmd_valid && !cmd_stall, cmd_stall)

  // No result can follow an accept in the very next cycle.
  `SKVT_ASSERT_NEXT(a_no_early_rsp, cmd_valid && !cmd_stall, !$rose(rsp_valid))

  // Only a found lookup carries a number.
  `SKVT_ASSERT_NOW(a_number_only_found, rsp_valid && (rsp.status != STATUS_FOUND),
                   rsp.found_number == '0)

endmodule

bind sorted_key_value_table skvt_checker u_checker (.*);
